@@ design/lcmi_pkg.sv @@
// ----------------------------------------------------------------------------
// LCM package
// Widths, shared-unit opcodes and the control and flag structs that pass
// between the sequencer and the shared add/subtract unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lcmi_pkg;

  // Operand width of both inputs and width of the result.
  localparam int OPERAND_WIDTH = 16;
  localparam int RESULT_WIDTH  = 32;

  // The shared unit must hold a division remainder (one bit over the operand)
  // and the low word of the product.
  localparam int UNIT_WIDTH  = (OPERAND_WIDTH + 1 > RESULT_WIDTH) ?
                               OPERAND_WIDTH + 1 : RESULT_WIDTH;

  // Counter for common factors of two and for division and multiply steps.
  localparam int COUNT_WIDTH = $clog2(OPERAND_WIDTH + 1);

  typedef logic [OPERAND_WIDTH-1:0] operand_t;
  typedef logic [RESULT_WIDTH-1:0]  result_t;
  typedef logic [UNIT_WIDTH-1:0]    unit_word_t;

  // Shared unit opcodes.
  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic op;
  } alu_ctrl_t;

  typedef struct packed {
    logic carry;  // carry out; on subtract, set when x >= y
    logic zero;   // result is all zeros
  } alu_flags_t;

endpackage

`default_nettype wire

@@ design/lcmi_alu.sv @@
// ----------------------------------------------------------------------------
// LCM shared arithmetic unit
// One add/subtract with carry and zero flags, used by the GCD, division and
// multiply phases: GCD compare and subtract, trial subtract, product sum.
// ----------------------------------------------------------------------------
`default_nettype none

module lcmi_alu (
  input  lcmi_pkg::unit_word_t x,
  input  lcmi_pkg::unit_word_t y,
  input  lcmi_pkg::alu_ctrl_t  ctrl,
  output lcmi_pkg::unit_word_t res,
  output lcmi_pkg::alu_flags_t flags
);
  import lcmi_pkg::*;

  logic [UNIT_WIDTH:0] sum;
  unit_word_t          y_op;

  // Subtract is done as x plus the inverted y plus one.
  assign y_op = (ctrl.op == ALU_SUB) ? ~y : y;
  assign sum  = {1'b0, x} + {1'b0, y_op} + {{UNIT_WIDTH{1'b0}}, (ctrl.op == ALU_SUB)};

  assign res         = sum[UNIT_WIDTH-1:0];
  assign flags.carry = sum[UNIT_WIDTH];
  assign flags.zero  = (sum[UNIT_WIDTH-1:0] == '0);

endmodule

`default_nettype wire

@@ design/lcm_two_integers_top.sv @@
// ----------------------------------------------------------------------------
// Least common multiple of two integers
// Binary GCD, restoring division and shift-add multiply on one shared unit.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. If either operand is
// zero, the result 0 appears on the cycle after the transfer and busy stays
// low. Otherwise busy rises for the whole computation. First comes a binary
// GCD loop, one compare or subtract a cycle, which ends when the two values
// are equal. Next the common factors of two are restored. For W-bit operands
// there follow W steps of restoring division of the first operand by the GCD
// and W steps of shift-add multiply by the second operand. The GCD, division
// and multiply phases all run on the single shared add/subtract unit. The
// result is shown for exactly one cycle with out_valid and is not held: the
// receiver must take it then. Only the low 32 bits of the multiple are given.
// ----------------------------------------------------------------------------
`default_nettype none

module lcm_two_integers_top (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    start,
  output logic                   busy,
  input  lcmi_pkg::operand_t     in_first_value,
  input  lcmi_pkg::operand_t     in_second_value,
  output logic                   out_valid,
  output lcmi_pkg::result_t      out_multiple
);
  import lcmi_pkg::*;

  localparam int OW = OPERAND_WIDTH;
  localparam int RW = RESULT_WIDTH;

  // Sequencer states.
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GCD   = 3'd1;
  localparam logic [2:0] S_ALIGN = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;

  localparam logic [COUNT_WIDTH-1:0] LAST_STEP = COUNT_WIDTH'(OW - 1);

  logic [2:0]             state_r, state_nxt;
  operand_t               a_r, a_nxt;
  operand_t               b_r, b_nxt;
  operand_t               q_r, q_nxt;
  logic [OW:0]            rem_r, rem_nxt;
  logic [COUNT_WIDTH-1:0] k_r, k_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  unit_word_t             acc_r, acc_nxt;
  result_t                mcand_r, mcand_nxt;
  logic                   out_valid_r, out_valid_nxt;
  result_t                out_multiple_r, out_multiple_nxt;

  unit_word_t             alu_x, alu_y, alu_res;
  alu_ctrl_t              alu_ctrl;
  alu_flags_t             alu_flags;
  logic [OW:0]            rem_shift;
  logic                   accept;

  assign accept    = start && (state_r == S_IDLE);
  assign rem_shift = {rem_r[OW-1:0], q_r[OW-1]};

  // Operand selection for the shared unit.
  always_comb begin
    alu_x       = unit_word_t'(a_r);
    alu_y       = unit_word_t'(b_r);
    alu_ctrl.op = ALU_SUB;
    unique case (state_r)
      S_DIV: begin
        alu_x = unit_word_t'(rem_shift);
        alu_y = unit_word_t'(a_r);
      end
      S_MUL: begin
        alu_x       = acc_r;
        alu_y       = q_r[0] ? unit_word_t'(mcand_r) : '0;
        alu_ctrl.op = ALU_ADD;
      end
      default: begin
        alu_x = unit_word_t'(a_r);
      end
    endcase
  end

  lcmi_alu u_alu (
    .x     (alu_x),
    .y     (alu_y),
    .ctrl  (alu_ctrl),
    .res   (alu_res),
    .flags (alu_flags)
  );

  // Sequencer and datapath next values.
  always_comb begin
    state_nxt        = state_r;
    a_nxt            = a_r;
    b_nxt            = b_r;
    q_nxt            = q_r;
    rem_nxt          = rem_r;
    k_nxt            = k_r;
    cnt_nxt          = cnt_r;
    acc_nxt          = acc_r;
    mcand_nxt        = mcand_r;
    out_valid_nxt    = 1'b0;
    out_multiple_nxt = out_multiple_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          a_nxt     = in_first_value;
          b_nxt     = in_second_value;
          q_nxt     = in_first_value;
          k_nxt     = '0;
          acc_nxt   = '0;
          mcand_nxt = result_t'(in_second_value);
          if ((in_first_value == '0) || (in_second_value == '0)) begin
            out_valid_nxt    = 1'b1;
            out_multiple_nxt = '0;
          end else begin
            state_nxt = S_GCD;
          end
        end
      end
      // Binary GCD: strip factors of two, subtract the smaller odd value.
      S_GCD: begin
        priority if (alu_flags.zero) begin
          state_nxt = S_ALIGN;
        end else if (!a_r[0] && !b_r[0]) begin
          a_nxt = a_r >> 1;
          b_nxt = b_r >> 1;
          k_nxt = k_r + 1'b1;
        end else if (!a_r[0]) begin
          a_nxt = a_r >> 1;
        end else if (!b_r[0]) begin
          b_nxt = b_r >> 1;
        end else if (alu_flags.carry) begin
          a_nxt = alu_res[OW:1];
        end else begin
          a_nxt = b_r;
          b_nxt = a_r;
        end
      end
      // Put the common factors of two back into the GCD.
      S_ALIGN: begin
        if (k_r == '0) begin
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end else begin
          a_nxt = a_r << 1;
          k_nxt = k_r - 1'b1;
        end
      end
      // Restoring division of the first operand by the GCD.
      S_DIV: begin
        if (alu_flags.carry) begin
          rem_nxt = alu_res[OW:0];
          q_nxt   = {q_r[OW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_shift;
          q_nxt   = {q_r[OW-2:0], 1'b0};
        end
        if (cnt_r == LAST_STEP) begin
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      // Shift-add multiply of the quotient by the second operand.
      S_MUL: begin
        acc_nxt   = alu_res;
        q_nxt     = q_r >> 1;
        mcand_nxt = mcand_r << 1;
        if (cnt_r == LAST_STEP) begin
          out_valid_nxt    = 1'b1;
          out_multiple_nxt = alu_res[RW-1:0];
          state_nxt        = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    a_r            <= a_nxt;
    b_r            <= b_nxt;
    q_r            <= q_nxt;
    rem_r          <= rem_nxt;
    k_r            <= k_nxt;
    cnt_r          <= cnt_nxt;
    acc_r          <= acc_nxt;
    mcand_r        <= mcand_nxt;
    out_multiple_r <= out_multiple_nxt;
  end

  assign busy         = (state_r != S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_multiple = out_multiple_r;

endmodule

`default_nettype wire

@@ design/lcmi_chk.sv @@
// ----------------------------------------------------------------------------
// LCM port checker
// Assertions on the top level's ports over time, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lcmi_chk (
  input wire                 clk,
  input wire                 rst_n,
  input wire                 start,
  input wire                 busy,
  input lcmi_pkg::operand_t  in_first_value,
  input lcmi_pkg::operand_t  in_second_value,
  input wire                 out_valid,
  input lcmi_pkg::result_t   out_multiple
);
  import lcmi_pkg::*;

  // A result is never shown while a computation is still running.
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // A zero operand gives 0 on the next cycle without going busy.
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && ((in_first_value == '0) || (in_second_value == '0)))
      |=> (out_valid && (out_multiple == '0) && !busy))
    else $error("zero operand did not give result 0");

  // A transfer of two nonzero operands starts a computation.
  a_nonzero_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_first_value != '0) && (in_second_value != '0))
      |=> (busy && !out_valid))
    else $error("nonzero transfer did not start a computation");

  // Every computation ends with its result shown on out_valid.
  a_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy)) |-> out_valid)
    else $error("computation ended without a result");

endmodule

bind lcm_two_integers_top lcmi_chk u_lcmi_chk (.*);

`default_nettype wire
